// ----- src/psc_pkg.sv -----
package psc_pkg;

    localparam int MAX_AGENTS = 16;
    localparam int IDX_W      = $clog2(MAX_AGENTS);
    localparam int CNT_W      = $clog2(MAX_AGENTS + 1);
    localparam int CW         = 16;   // coordinate width, Q8.8
    localparam int RW         = 16;   // radius width, Q8.8
    localparam int MW         = 12;   // margin width, Q4.8
    localparam int TW         = 7;    // pair total width
    localparam int WORD_W     = 3 * CW + RW;

    localparam logic [TW-1:0] TOTAL_MAX  = '1;
    localparam logic [MW-1:0] MARGIN_RST = MW'(256);

    // command handed from front to back
    typedef struct packed {
        logic                 start;
        logic                 ovf;
        logic [IDX_W-1:0]     idx;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [RW-1:0]        r;
    } t_cmd;

    // one pipeline token: a stored entry to test, or the end of a command
    typedef struct packed {
        logic             valid;
        logic             end_tok;
        logic             first;
        logic             start;
        logic             ovf;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] j;
    } t_tok;

endpackage

// ----- src/psc_ram.sv -----
module psc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/psc_front.sv -----
module psc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_start_set,
    input  logic [psc_pkg::CW-1:0] i_pos_x,
    input  logic [psc_pkg::CW-1:0] i_pos_y,
    input  logic [psc_pkg::CW-1:0] i_pos_z,
    input  logic [psc_pkg::RW-1:0] i_radius,
    input  logic                 i_full,
    output logic                 o_push,
    output psc_pkg::t_cmd        o_cmd
);
    import psc_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] n_cnt;
    logic             ovf;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign cnt_eff = i_start_set ? '0 : r_cnt;
    assign ovf     = (cnt_eff == CNT_W'(MAX_AGENTS));
    assign n_cnt   = ovf ? cnt_eff : cnt_eff + CNT_W'(1);

    always_comb begin
        o_cmd.start = i_start_set;
        o_cmd.ovf   = ovf;
        o_cmd.idx   = ovf ? '0 : cnt_eff[IDX_W-1:0];
        o_cmd.x     = i_pos_x;
        o_cmd.y     = i_pos_y;
        o_cmd.z     = i_pos_z;
        o_cmd.r     = i_radius;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_push) begin
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_AGENTS)) else $error("agent count past capacity");
    a_start_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_start_set) |-> (!o_cmd.ovf && o_cmd.idx == '0))
        else $error("new set does not start at index zero");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !ovf) |=> (r_cnt == $past(cnt_eff) + CNT_W'(1)))
        else $error("count did not advance");
endmodule

// ----- src/psc_cmd_fifo.sv -----
module psc_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  psc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output psc_pkg::t_cmd o_cmd
);
    import psc_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers out of step");
endmodule

// ----- src/psc_back.sv -----
module psc_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [psc_pkg::MW-1:0]  i_margin,
    input  logic                    i_empty,
    input  psc_pkg::t_cmd           i_cmd,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [psc_pkg::IDX_W-1:0] o_new_index,
    output logic [psc_pkg::IDX_W-1:0] o_other_index,
    output logic                    o_pair_valid,
    output logic [psc_pkg::TW-1:0]  o_collision_total,
    output logic                    o_capacity_overflow,
    output logic                    o_last_result
);
    import psc_pkg::*;

    logic adv;

    // scan sequencer
    logic             r_busy;
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_j;
    t_tok             issue;

    // stage registers
    t_tok                 r_s1, r_s2, r_s3, r_s4;
    logic signed [CW-1:0] r_s1_x, r_s1_y, r_s1_z;
    logic [RW-1:0]        r_s1_r;
    logic [WORD_W-1:0]    rd_word;
    logic signed [CW-1:0] st_x, st_y, st_z;
    logic [RW-1:0]        st_r;
    logic signed [CW:0]   r_dx, r_dy, r_dz;
    logic [CW-1:0]        ax, ay, az;
    logic [2*CW-1:0]      sq_x, sq_y, sq_z;
    logic [RW:0]          r_rsum;
    logic [2*CW+1:0]      r_qx, r_qy, r_qz;
    logic [RW+MW:0]       r_th;
    logic [2*CW+3:0]      r_d2;
    logic [2*(RW+MW)+1:0] r_th2;
    logic                 hit;

    // result assembly
    logic [TW-1:0]    r_total;
    logic             r_pend_valid;
    logic [IDX_W-1:0] r_pend_idx, r_pend_j;
    logic [TW-1:0]    r_pend_total;
    logic [TW-1:0]    tot_base, tot_inc;
    logic             r_ovalid;
    logic [IDX_W-1:0] r_o_new, r_o_other;
    logic             r_o_pair, r_o_ovf, r_o_last;
    logic [TW-1:0]    r_o_total;

    assign adv   = !r_ovalid || i_ready;
    assign o_pop = !r_busy && !i_empty;

    always_comb begin
        issue.valid   = r_busy;
        issue.end_tok = r_cmd.ovf || (r_j == r_cmd.idx);
        issue.first   = (r_j == '0);
        issue.start   = r_cmd.start;
        issue.ovf     = r_cmd.ovf;
        issue.idx     = r_cmd.idx;
        issue.j       = r_j;
    end

    // the new agent goes in at pop; its own scan tests only lower entries
    psc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_AGENTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (o_pop && !i_cmd.ovf),
        .i_waddr(i_cmd.idx),
        .i_wdata({i_cmd.x, i_cmd.y, i_cmd.z, i_cmd.r}),
        .i_re   (adv),
        .i_raddr(r_j),
        .o_rdata(rd_word)
    );

    assign {st_x, st_y, st_z, st_r} = rd_word;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_j    <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_j    <= '0;
        end else if (r_busy && adv) begin
            if (issue.end_tok) begin
                r_busy <= 1'b0;
            end else begin
                r_j <= r_j + IDX_W'(1);
            end
        end
    end

    // magnitudes fit in CW bits, so the squares are CW x CW
    assign ax   = r_dx[CW] ? CW'(-r_dx) : r_dx[CW-1:0];
    assign ay   = r_dy[CW] ? CW'(-r_dy) : r_dy[CW-1:0];
    assign az   = r_dz[CW] ? CW'(-r_dz) : r_dz[CW-1:0];
    assign sq_x = ax * ax;
    assign sq_y = ay * ay;
    assign sq_z = az * az;

    // datapath: diff, square, sum, compare
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_x <= r_cmd.x;
            r_s1_y <= r_cmd.y;
            r_s1_z <= r_cmd.z;
            r_s1_r <= r_cmd.r;
            r_dx   <= {r_s1_x[CW-1], r_s1_x} - {st_x[CW-1], st_x};
            r_dy   <= {r_s1_y[CW-1], r_s1_y} - {st_y[CW-1], st_y};
            r_dz   <= {r_s1_z[CW-1], r_s1_z} - {st_z[CW-1], st_z};
            r_rsum <= {1'b0, r_s1_r} + {1'b0, st_r};
            r_qx   <= {2'b00, sq_x};
            r_qy   <= {2'b00, sq_y};
            r_qz   <= {2'b00, sq_z};
            r_th   <= r_rsum * i_margin;
            r_d2   <= {2'b00, r_qx} + {2'b00, r_qy} + {2'b00, r_qz};
            r_th2  <= r_th * r_th;
        end
    end

    assign hit = ({r_d2, 16'h0000} < r_th2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
        end else if (adv) begin
            r_s1 <= issue;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= r_s3;
        end
    end

    assign tot_base = (r_s4.first && r_s4.start) ? '0 : r_total;
    assign tot_inc  = (tot_base == TOTAL_MAX) ? tot_base : tot_base + TW'(1);

    // a hit is held back until the next hit or the end token, so the last one can carry the flag
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_s4.valid && r_s4.ovf) begin
                r_o_new   <= '0;
                r_o_other <= '0;
                r_o_pair  <= 1'b0;
                r_o_total <= tot_base;
                r_o_ovf   <= 1'b1;
                r_o_last  <= 1'b1;
            end else if (r_pend_valid) begin
                r_o_new   <= r_pend_idx;
                r_o_other <= r_pend_j;
                r_o_pair  <= 1'b1;
                r_o_total <= r_pend_total;
                r_o_ovf   <= 1'b0;
                r_o_last  <= r_s4.end_tok;
            end else begin
                r_o_new   <= r_s4.idx;
                r_o_other <= '0;
                r_o_pair  <= 1'b0;
                r_o_total <= tot_base;
                r_o_ovf   <= 1'b0;
                r_o_last  <= 1'b1;
            end
            if (r_s4.valid && !r_s4.end_tok && hit) begin
                r_pend_idx   <= r_s4.idx;
                r_pend_j     <= r_s4.j;
                r_pend_total <= tot_inc;
            end
        end
        if (!i_rst_n) begin
            r_total      <= '0;
            r_pend_valid <= 1'b0;
            r_ovalid     <= 1'b0;
        end else if (adv) begin
            r_ovalid <= 1'b0;
            if (r_s4.valid) begin
                if (r_s4.end_tok) begin
                    r_total      <= tot_base;
                    r_pend_valid <= 1'b0;
                    r_ovalid     <= 1'b1;
                end else if (hit) begin
                    r_total      <= tot_inc;
                    r_pend_valid <= 1'b1;
                    r_ovalid     <= r_pend_valid;
                end else begin
                    r_total <= tot_base;
                end
            end
        end
    end

    assign o_valid             = r_ovalid;
    assign o_new_index         = r_o_new;
    assign o_other_index       = r_o_other;
    assign o_pair_valid        = r_o_pair;
    assign o_collision_total   = r_o_total;
    assign o_capacity_overflow = r_o_ovf;
    assign o_last_result       = r_o_last;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s4.valid && r_s4.end_tok) |=> !r_pend_valid)
        else $error("pending hit survived end of scan");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && !r_cmd.ovf && r_j > r_cmd.idx)) else $error("scan past new index");
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_busy) else $error("store written during scan");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_s4)) else $error("pipeline moved under stall");
endmodule

// ----- src/pairwise_sphere_collision_detector.sv -----
// Results: with k agents stored, an agent's last result follows its scan of those k; each
// earlier pair leaves as the next colliding pair is found.
// The scan reads one stored entry per cycle while the output is not stalled (the longest
// scan is the sixteenth agent against fifteen); a new agent waits until the last scan ends.
// Reset (synchronous, active low) empties the set, clears the total and the queue,
// and loads the safety margin with 1.0; the agent store itself is not cleared.
module pairwise_sphere_collision_detector (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // margin register, Q4.8
    input  logic                    i_cfg_we,
    input  logic [psc_pkg::MW-1:0]  i_cfg_data,
    // agent beats
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_start_set,
    input  logic [psc_pkg::CW-1:0]  i_pos_x,
    input  logic [psc_pkg::CW-1:0]  i_pos_y,
    input  logic [psc_pkg::CW-1:0]  i_pos_z,
    input  logic [psc_pkg::RW-1:0]  i_radius,
    // result beats
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [psc_pkg::IDX_W-1:0] o_new_index,
    output logic [psc_pkg::IDX_W-1:0] o_other_index,
    output logic                    o_pair_valid,
    output logic [psc_pkg::TW-1:0]  o_collision_total,
    output logic                    o_capacity_overflow,
    output logic                    o_last_result
);
    import psc_pkg::*;

    logic [MW-1:0] r_margin;
    logic          push, full, pop, empty;
    t_cmd          cmd_in, cmd_out;

    // the user must write the margin only while the block is idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RST;
        end else if (i_cfg_we) begin
            r_margin <= i_cfg_data;
        end
    end

    // front: tracks set fill, assigns index, flags overflow
    psc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_start_set(i_start_set),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_radius   (i_radius),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (cmd_in)
    );

    // two-entry command queue decouples intake from the scan
    psc_cmd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd_in),
        .o_full (full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_cmd  (cmd_out)
    );

    // back: stores the agent, scans earlier ones, emits pair and end-of-scan beats
    psc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_margin           (r_margin),
        .i_empty            (empty),
        .i_cmd              (cmd_out),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_new_index        (o_new_index),
        .o_other_index      (o_other_index),
        .o_pair_valid       (o_pair_valid),
        .o_collision_total  (o_collision_total),
        .o_capacity_overflow(o_capacity_overflow),
        .o_last_result      (o_last_result)
    );
endmodule
